>>> rtl/tgpf_pkg.sv
// ----------------------------------------------------------------------------
// tgpf_pkg
// Shared types, constants and the quarter-wave sine entry function.
// ----------------------------------------------------------------------------
package tgpf_pkg;

  localparam int unsigned CHANNELS_DEF   = 2;
  localparam int unsigned SINE_DEPTH_DEF = 1024;
  localparam int unsigned PCM_BITS       = 16;

  localparam int unsigned CH_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned QW_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_VOLUME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_LEFT_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_RIGHT_ON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 3'd7;

  // output format bits
  localparam int unsigned FMT_OFFSET_BIT = 0;
  localparam int unsigned FMT_SWAP_BIT   = 1;

  localparam logic [15:0] UNITY_Q412 = 16'd4096;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic        test_mode;
    logic [31:0] phase_step;
    logic [15:0] test_volume;
    logic        test_left_on;
    logic        test_right_on;
    logic [15:0] gain_left;
    logic [15:0] gain_right;
    logic [1:0]  output_format;
  } tgpf_cfg_t;

  // sine magnitude for a Q30 angle x, Taylor series to the 11th order
  function automatic logic [QW_W-1:0] qwave_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return v[QW_W-1:0];
  endfunction

endpackage

>>> rtl/tgpf_cfg.sv
// ----------------------------------------------------------------------------
// tgpf_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
module tgpf_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgpf_pkg::CFG_DAT_W-1:0]      cfg_data,
  output tgpf_pkg::tgpf_cfg_t                 cfg
);
  import tgpf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.test_mode     <= 1'b0;
      cfg.phase_step    <= '0;
      cfg.test_volume   <= UNITY_Q412;
      cfg.test_left_on  <= 1'b1;
      cfg.test_right_on <= 1'b1;
      cfg.gain_left     <= UNITY_Q412;
      cfg.gain_right    <= UNITY_Q412;
      cfg.output_format <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEST_MODE:     cfg.test_mode     <= cfg_data[0];
        REG_PHASE_STEP:    cfg.phase_step    <= cfg_data[31:0];
        REG_TEST_VOLUME:   cfg.test_volume   <= cfg_data[15:0];
        REG_TEST_LEFT_ON:  cfg.test_left_on  <= cfg_data[0];
        REG_TEST_RIGHT_ON: cfg.test_right_on <= cfg_data[0];
        REG_GAIN_LEFT:     cfg.gain_left     <= cfg_data[15:0];
        REG_GAIN_RIGHT:    cfg.gain_right    <= cfg_data[15:0];
        REG_OUTPUT_FORMAT: cfg.output_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tgpf_mul.sv
// ----------------------------------------------------------------------------
// tgpf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tgpf_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [tgpf_pkg::MUL_A_W-1:0]  a,
  input  logic signed [tgpf_pkg::MUL_B_W-1:0]  b,
  output logic signed [tgpf_pkg::MUL_P_W-1:0]  p
);
  import tgpf_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

>>> rtl/tgpf_rom.sv
// ----------------------------------------------------------------------------
// tgpf_rom
// Quarter-wave sine table, built at elaboration, with a registered read.
// ----------------------------------------------------------------------------
module tgpf_rom #(
  parameter int unsigned DEPTH = tgpf_pkg::SINE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  output logic [tgpf_pkg::QW_W-1:0]    data
);
  import tgpf_pkg::*;

  logic [QW_W-1:0] rom_tab [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    // angle at the middle of entry k, pi/2 * (k + 0.5) / DEPTH in Q30
    localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * DEPTH);
    localparam logic [QW_W-1:0] VK = qwave_entry(XK);
    assign rom_tab[k] = VK;
  end

  always_ff @(posedge clk) begin
    data <= rom_tab[addr];
  end

endmodule

>>> rtl/tone_gain_pcm_formatter_top.sv
// ----------------------------------------------------------------------------
// tone_gain_pcm_formatter_top
// Test tone generator, gain stage and 16-bit PCM formatter.
// ----------------------------------------------------------------------------
// One channel sample per word enters on s_axis (tdata: ext_sample, tuser:
// channel, tlast: end of buffer). One PCM word leaves on m_axis for each
// word taken in (tdata: pcm_word, tuser: channel and clip flag, tlast: end
// of buffer passed through). Registers are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// A small sequencer runs every sample through one shared multiplier:
// in test mode the word passes the table index, table read, tone scale,
// round, gain and saturate steps before it reaches the output register,
// otherwise only the gain and saturate steps. s_axis_tready is high only
// while the sequencer is idle, so at most one sample is in flight and a
// new word is taken only after the last one has left the sequencer.
// The result sits in an output register; a new sample is taken while it
// waits, and the sequencer holds in its last step while m_axis is stalled.
// Reset clears the tone phase, restores register defaults and drops
// m_axis_tvalid. The sine table is a constant ROM, no fill time needed.
// ----------------------------------------------------------------------------
module tone_gain_pcm_formatter_top #(
  parameter int unsigned CHANNELS         = tgpf_pkg::CHANNELS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = tgpf_pkg::SINE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // ext_sample
  input  logic                             s_axis_tlast,
  input  logic [tgpf_pkg::CH_W-1:0]        s_axis_tuser,  // channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // pcm_word
  output logic                             m_axis_tlast,
  output logic [tgpf_pkg::CH_W:0]          m_axis_tuser,  // out_channel, clipped
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tgpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgpf_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import tgpf_pkg::*;

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IDX  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_TONE = 3'd3;
  localparam logic [2:0] S_TRND = 3'd4;
  localparam logic [2:0] S_GAIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  tgpf_cfg_t cfg;

  logic [2:0]                 state;
  logic [31:0]                tone_phase;
  logic [CH_W-1:0]            ch;
  logic                       eob;
  logic signed [20:0]         t_val;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [MUL_P_W-1:0]  rnd;

  logic [IW-1:0]              idx_raw;
  logic [IW-1:0]              idx_cl;
  logic [AW-1:0]              rom_addr;
  logic [QW_W-1:0]            rom_q;
  logic signed [15:0]         sine_s;
  logic [15:0]                vol;
  logic [15:0]                gain;

  logic [15:0]                sat_w;
  logic                       sat_clip;
  logic [15:0]                fmt_w;

  logic                       out_valid;
  logic [15:0]                out_pcm;
  logic [CH_W-1:0]            out_ch;
  logic                       out_eob;
  logic                       out_clip;
  logic                       out_free;
  logic                       in_acc;

  tgpf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgpf_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tgpf_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // table index from phase * depth, mirrored in odd quadrants
  assign idx_raw  = mul_p[30 +: IW];
  assign idx_cl   = (idx_raw >= IW'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH - 1) : idx_raw;
  assign rom_addr = tone_phase[30] ? (AW'(SINE_TABLE_DEPTH - 1) - idx_cl[AW-1:0])
                                   : idx_cl[AW-1:0];

  assign sine_s = tone_phase[31] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    vol = cfg.test_volume;
    if (ch == CH_W'(0) && !cfg.test_left_on) begin
      vol = '0;
    end
    if (ch == CH_W'(1) && !cfg.test_right_on) begin
      vol = '0;
    end
  end

  assign gain = (ch == CH_W'(0)) ? cfg.gain_left : cfg.gain_right;

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(t_val);
    mul_b  = $signed({1'b0, gain});
    unique case (state)
      S_IDX: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, tone_phase[29:0]});
        mul_b  = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      S_TONE: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(sine_s);
        mul_b  = $signed({1'b0, vol});
      end
      S_GAIN: begin
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  // round half up after dropping 12 fraction bits
  assign rnd = (mul_p + MUL_P_W'(2048)) >>> 12;

  always_comb begin
    sat_clip = 1'b0;
    sat_w    = rnd[15:0];
    if (rnd > MUL_P_W'(32767)) begin
      sat_w    = 16'h7FFF;
      sat_clip = 1'b1;
    end else if (rnd < -MUL_P_W'(32768)) begin
      sat_w    = 16'h8000;
      sat_clip = 1'b1;
    end
  end

  always_comb begin
    fmt_w = sat_w;
    if (cfg.output_format[FMT_OFFSET_BIT]) begin
      fmt_w = fmt_w ^ 16'h8000;
    end
    if (cfg.output_format[FMT_SWAP_BIT]) begin
      fmt_w = {fmt_w[7:0], fmt_w[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tone_phase <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= cfg.test_mode ? S_IDX : S_GAIN;
          end
        end
        S_IDX:  state <= S_ADDR;
        S_ADDR: state <= S_TONE;
        S_TONE: state <= S_TRND;
        S_TRND: begin
          if (ch == CH_W'(CHANNELS - 1)) begin
            tone_phase <= tone_phase + cfg.phase_step;
          end
          state <= S_GAIN;
        end
        S_GAIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch    <= s_axis_tuser;
      eob   <= s_axis_tlast;
      t_val <= 21'(signed'(s_axis_tdata));
    end
    if (state == S_TRND) begin
      t_val <= rnd[20:0];
    end
    if (state == S_OUT && out_free) begin
      out_pcm  <= fmt_w;
      out_ch   <= ch;
      out_eob  <= eob;
      out_clip <= sat_clip;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pcm;
  assign m_axis_tlast  = out_eob;
  assign m_axis_tuser  = {out_clip, out_ch};

  a_plain_path: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !cfg.test_mode) |=> (state == S_GAIN))
    else $error("non-test sample did not go straight to the gain step");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_OUT))
    else $error("output word loaded outside the final step");

  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (!$stable(tone_phase) && !$past(rst)) |-> ($past(state) == S_TRND))
    else $error("tone phase moved outside the round step");

  a_addr_after_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ($past(state) == S_IDX))
    else $error("table read without an index product");

endmodule
